FILE: rtl/lloc_pkg.sv
// Shared constants for the lane locator.
`default_nettype none
package lloc_pkg;
	localparam int FRAC_BITS = 8;
	localparam int HALF_Q8 = 128;
	localparam int IDX_W = 3;
	localparam int TYPE_W = 8;
	localparam int LANE_W = 4;
	localparam int WIDTH_W = 16;
	localparam int LTYPE_W = 9;
	localparam int LC_W = 4;
	localparam int ROI_W = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROI_LEFT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROI_TOP = 2'd2;

	localparam logic [LC_W-1:0] LINE_COUNT_RST = 4'd2;

	// handshake between the request queue and the line walker
	typedef struct packed {
		logic valid;
		logic pop;
	} q_ctl_t;
endpackage
`default_nettype wire

FILE: rtl/lloc_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module lloc_div #(
	parameter int NW = 20,
	parameter int DW = 12
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic signed [NW:0]  num,
	input  wire logic signed [DW:0]  den,
	output logic                     done,
	output logic signed [NW:0]       quo
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] acc_q;
	logic [DW-1:0] dmag_q;
	logic [DW:0]   rem_q;
	logic          neg_q;
	logic          run_q;
	logic [CW-1:0] cnt_q;

	logic [NW:0]   num_abs;
	logic [DW:0]   den_abs;
	logic [DW+1:0] rem_sh;
	logic          fits;

	assign num_abs = num[NW] ? (NW+1)'(0) - num : num;
	assign den_abs = den[DW] ? (DW+1)'(0) - den : den;
	assign rem_sh = {rem_q, acc_q[NW-1]};
	assign fits = rem_sh >= (DW+2)'(dmag_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= num_abs[NW-1:0];
			dmag_q <= den_abs[DW-1:0];
			rem_q <= '0;
			neg_q <= num[NW] ^ den[DW];
		end else if (run_q) begin
			// shift in the next dividend bit, subtract when it fits
			rem_q <= fits ? (DW+1)'(rem_sh - (DW+2)'(dmag_q)) : rem_sh[DW:0];
			acc_q <= {acc_q[NW-2:0], fits};
		end
	end

	assign quo = neg_q ? (NW+1)'(0) - {1'b0, acc_q} : {1'b0, acc_q};
endmodule
`default_nettype wire

FILE: rtl/lloc_front.sv
// Request intake: classify, drop out-of-range loads, queue the rest.
`default_nettype none
module lloc_front #(
	parameter int MAX_LINES = 8,
	parameter int COORD_BITS = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire logic kind,
	input  wire logic [lloc_pkg::IDX_W-1:0]  line_index,
	input  wire logic [COORD_BITS-1:0]       top_x,
	input  wire logic [COORD_BITS-1:0]       top_y,
	input  wire logic [COORD_BITS-1:0]       bottom_x,
	input  wire logic [COORD_BITS-1:0]       bottom_y,
	input  wire logic [lloc_pkg::TYPE_W-1:0] line_type,
	input  wire logic [COORD_BITS-1:0]       point_x,
	input  wire logic [COORD_BITS-1:0]       point_y,
	output logic [1+lloc_pkg::IDX_W+6*COORD_BITS+lloc_pkg::TYPE_W-1:0] q_item,
	output lloc_pkg::q_ctl_t                 q_ctl_out,
	input  wire logic                        q_pop
);
	localparam int ITEM_W = 1 + lloc_pkg::IDX_W + 6*COORD_BITS + lloc_pkg::TYPE_W;

	logic [ITEM_W-1:0] slot_q [2];
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              drop, push, pop;

	assign busy = cnt_q == 2'd2;
	assign drop = (kind == lloc_pkg::KIND_LOAD) && (32'(line_index) >= MAX_LINES);
	assign push = start && !busy && !drop;
	assign pop = q_pop && (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= {kind, line_index, top_x, top_y, bottom_x, bottom_y,
				line_type, point_x, point_y};
		end
	end

	assign q_item = slot_q[rd_ptr_q];
	assign q_ctl_out.valid = cnt_q != 2'd0;
	assign q_ctl_out.pop = pop;
endmodule
`default_nettype wire

FILE: rtl/lloc_back.sv
// Line table and line walker: evaluates lines one at a time on a shared divider.
`default_nettype none
module lloc_back #(
	parameter int MAX_LINES = 8,
	parameter int COORD_BITS = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [1+lloc_pkg::IDX_W+6*COORD_BITS+lloc_pkg::TYPE_W-1:0] q_item,
	input  wire lloc_pkg::q_ctl_t                q_ctl_in,
	output logic                                 q_pop,
	input  wire logic [lloc_pkg::LC_W-1:0]       line_count,
	input  wire logic [lloc_pkg::ROI_W-1:0]      roi_left,
	input  wire logic [lloc_pkg::ROI_W-1:0]      roi_top,
	output logic                                 done,
	output logic [lloc_pkg::LANE_W-1:0]          lane_number,
	output logic [lloc_pkg::WIDTH_W-1:0]         lane_width,
	output logic [lloc_pkg::LTYPE_W-1:0]         lane_type
);
	localparam int C = COORD_BITS;
	localparam int IW = $clog2(MAX_LINES);
	localparam int PXW = ((C > lloc_pkg::ROI_W) ? C : lloc_pkg::ROI_W) + 1;
	localparam int NW = C + lloc_pkg::FRAC_BITS;
	localparam int PW = NW + 1 + PXW + 1;
	localparam int XW = PW + 2;
	localparam int F = lloc_pkg::FRAC_BITS;
	localparam int TW = lloc_pkg::TYPE_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FETCH = 3'd1;
	localparam logic [2:0] ST_SETUP = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_MUL = 3'd4;
	localparam logic [2:0] ST_ADD = 3'd5;
	localparam logic [2:0] ST_CHECK = 3'd6;
	localparam logic [2:0] ST_OUT = 3'd7;

	logic          h_kind;
	logic [lloc_pkg::IDX_W-1:0] h_idx;
	logic [C-1:0]  h_tx, h_ty, h_bx, h_by, h_px, h_py;
	logic [TW-1:0] h_type;
	assign {h_kind, h_idx, h_tx, h_ty, h_bx, h_by, h_type, h_px, h_py} = q_item;

	logic [C-1:0]  tab_tx [MAX_LINES];
	logic [C-1:0]  tab_ty [MAX_LINES];
	logic [C-1:0]  tab_bx [MAX_LINES];
	logic [C-1:0]  tab_by [MAX_LINES];
	logic [TW-1:0] tab_type [MAX_LINES];

	logic [2:0]    state_q;
	logic [IW-1:0] i_q, m_q, rd_idx;
	logic          swap_q;
	logic [PXW-1:0] px_q, py_q;
	logic [C-1:0]  ax_q, ay_q, cx_q, cy_q;
	logic [TW-1:0] cur_type_q, prev_type_q;
	logic signed [PXW:0]  row_q;
	logic signed [NW:0]   slope_q;
	logic signed [PW-1:0] prod_q;
	logic signed [XW-1:0] x_q, prev_q, x0_q;
	logic [XW:0]   gap_q;
	logic [lloc_pkg::LANE_W-1:0]  lane_q;
	logic [lloc_pkg::LTYPE_W-1:0] ltype_q;

	logic signed [C:0]  dx_raw, dy_raw, dx, dy;
	logic               div_start, div_done;
	logic signed [NW:0] div_quo;
	logic               found;
	logic signed [XW-1:0] x_int, px_ext;
	logic [XW:0]        w_round;
	logic [4:0]         lc_ext;

	assign rd_idx = swap_q ? IW'(1) : i_q;
	assign dx_raw = $signed({1'b0, cx_q}) - $signed({1'b0, ax_q});
	assign dy_raw = $signed({1'b0, cy_q}) - $signed({1'b0, ay_q});
	assign dx = (dx_raw == '0) ? (C+1)'(1) : dx_raw;
	assign dy = (dy_raw == '0) ? (C+1)'(1) : dy_raw;
	assign div_start = state_q == ST_SETUP;

	lloc_div #(.NW(NW), .DW(C)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({dx, {F{1'b0}}}), .den(dy), .done(div_done), .quo(div_quo)
	);

	// x truncated toward zero at or right of the point
	assign x_int = x_q >>> F;
	assign px_ext = $signed({{(XW-PXW){1'b0}}, px_q});
	assign found = x_q[XW-1] ? ((px_q == '0) && (&x_q[XW-1:F]) && (x_q[F-1:0] != '0))
		: (x_int >= px_ext);

	assign w_round = (gap_q + (XW+1)'(lloc_pkg::HALF_Q8)) >> F;
	assign lc_ext = {1'b0, line_count};
	assign q_pop = (state_q == ST_IDLE) && q_ctl_in.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_ctl_in.valid && (h_kind == lloc_pkg::KIND_QUERY)) state_q <= ST_FETCH;
				end
				ST_FETCH: state_q <= ST_SETUP;
				ST_SETUP: state_q <= ST_DIV;
				ST_DIV:   if (div_done) state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_ADD;
				ST_ADD:   state_q <= ST_CHECK;
				ST_CHECK: begin
					if (swap_q) state_q <= ST_OUT;
					else if (found) state_q <= (i_q == '0) ? ST_FETCH : ST_OUT;
					else if (i_q == m_q) state_q <= ST_OUT;
					else state_q <= ST_FETCH;
				end
				ST_OUT: begin
					done <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (q_ctl_in.valid && (h_kind == lloc_pkg::KIND_LOAD)) begin
					tab_tx[IW'(h_idx)] <= h_tx;
					tab_ty[IW'(h_idx)] <= h_ty;
					tab_bx[IW'(h_idx)] <= h_bx;
					tab_by[IW'(h_idx)] <= h_by;
					tab_type[IW'(h_idx)] <= h_type;
				end
				i_q <= '0;
				swap_q <= 1'b0;
				px_q <= PXW'(h_px) + PXW'(roi_left);
				py_q <= PXW'(h_py) + PXW'(roi_top);
				if (lc_ext < 5'd2) m_q <= IW'(1);
				else if (32'(lc_ext) > MAX_LINES) m_q <= IW'(MAX_LINES - 1);
				else m_q <= IW'(lc_ext - 5'd1);
			end
			ST_FETCH: begin
				if (swap_q) begin
					ax_q <= tab_bx[rd_idx];
					ay_q <= tab_by[rd_idx];
					cx_q <= tab_tx[rd_idx];
					cy_q <= tab_ty[rd_idx];
				end else begin
					ax_q <= tab_tx[rd_idx];
					ay_q <= tab_ty[rd_idx];
					cx_q <= tab_bx[rd_idx];
					cy_q <= tab_by[rd_idx];
				end
				cur_type_q <= tab_type[rd_idx];
			end
			ST_SETUP: row_q <= $signed({1'b0, py_q}) - $signed((PXW+1)'(ay_q));
			ST_DIV:   slope_q <= div_quo;
			ST_MUL:   prod_q <= PW'(slope_q * row_q);
			ST_ADD:   x_q <= $signed(XW'({ax_q, {F{1'b0}}})) + XW'(prod_q)
				+ XW'(lloc_pkg::HALF_Q8);
			ST_CHECK: begin
				if (swap_q) begin
					// point left of every line: gap to line one taken from its bottom end
					gap_q <= (x0_q >= x_q) ? (XW+1)'(x0_q - x_q) : (XW+1)'(x_q - x0_q);
					lane_q <= '1;
					ltype_q <= '1;
				end else if (found && (i_q == '0)) begin
					x0_q <= x_q;
					swap_q <= 1'b1;
				end else if (found || (i_q == m_q)) begin
					gap_q <= (x_q >= prev_q) ? (XW+1)'(x_q - prev_q) : (XW+1)'(prev_q - x_q);
					if (found) begin
						lane_q <= lloc_pkg::LANE_W'(i_q - IW'(1));
						ltype_q <= {1'b0, prev_type_q};
					end else begin
						lane_q <= '1;
						ltype_q <= '1;
					end
				end else begin
					prev_q <= x_q;
					prev_type_q <= cur_type_q;
					i_q <= i_q + IW'(1);
				end
			end
			ST_OUT: begin
				lane_number <= lane_q;
				lane_type <= ltype_q;
				if (gap_q == '0) lane_width <= lloc_pkg::WIDTH_W'(1);
				else if (w_round > (XW+1)'(16'hFFFF)) lane_width <= '1;
				else lane_width <= lloc_pkg::WIDTH_W'(w_round);
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/lane_locator_unit.sv
// Lane locator top level: config registers, request queue and line walker.
//
// Usage: software first writes line requests (kind = load), one per boundary
// line, ordered left to right, then issues point queries (kind = query).
// A request is taken when start is high and busy is low. Loads produce no
// result. Each query produces one result, shown on lane_number, lane_width
// and lane_type for exactly one cycle with done high; there is no back
// pressure, so the receiver must take it in that cycle.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 line
// count, 1 roi_left, 2 roi_top) at once; write only while idle.
// A two-entry queue parts intake from the walker, so up to two
// requests are taken while a query is in flight. A query evaluates
// the lines in order, each at most once, on a shared bit-serial divider,
// up to MAX_LINES lines (a point left of all lines takes two).
// Reset clears the queue, the walker and the registers
// (line count 2, offsets 0); the line table holds garbage until loaded.
`default_nettype none
module lane_locator_unit #(
	parameter int MAX_LINES = 8,
	parameter int COORD_BITS = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire logic kind,
	input  wire logic [lloc_pkg::IDX_W-1:0]  line_index,
	input  wire logic [COORD_BITS-1:0]       top_x,
	input  wire logic [COORD_BITS-1:0]       top_y,
	input  wire logic [COORD_BITS-1:0]       bottom_x,
	input  wire logic [COORD_BITS-1:0]       bottom_y,
	input  wire logic [lloc_pkg::TYPE_W-1:0] line_type,
	input  wire logic [COORD_BITS-1:0]       point_x,
	input  wire logic [COORD_BITS-1:0]       point_y,
	input  wire logic                        cfg_we,
	input  wire logic [lloc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lloc_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                             done,
	output logic [lloc_pkg::LANE_W-1:0]      lane_number,
	output logic [lloc_pkg::WIDTH_W-1:0]     lane_width,
	output logic [lloc_pkg::LTYPE_W-1:0]     lane_type
);
	localparam int ITEM_W = 1 + lloc_pkg::IDX_W + 6*COORD_BITS + lloc_pkg::TYPE_W;

	logic [lloc_pkg::LC_W-1:0]  line_count_q;
	logic [lloc_pkg::ROI_W-1:0] roi_left_q, roi_top_q;
	logic [ITEM_W-1:0]          q_item;
	lloc_pkg::q_ctl_t           q_ctl;
	logic                       q_pop;

	// config writes land immediately; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= lloc_pkg::LINE_COUNT_RST;
			roi_left_q <= '0;
			roi_top_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lloc_pkg::CFG_LINE_COUNT: line_count_q <= lloc_pkg::LC_W'(cfg_data);
				lloc_pkg::CFG_ROI_LEFT:   roi_left_q <= cfg_data;
				lloc_pkg::CFG_ROI_TOP:    roi_top_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// intake and queue
	lloc_front #(.MAX_LINES(MAX_LINES), .COORD_BITS(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.line_index(line_index), .top_x(top_x), .top_y(top_y),
		.bottom_x(bottom_x), .bottom_y(bottom_y), .line_type(line_type),
		.point_x(point_x), .point_y(point_y),
		.q_item(q_item), .q_ctl_out(q_ctl), .q_pop(q_pop)
	);

	// table and walker
	lloc_back #(.MAX_LINES(MAX_LINES), .COORD_BITS(COORD_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_item(q_item), .q_ctl_in(q_ctl), .q_pop(q_pop),
		.line_count(line_count_q), .roi_left(roi_left_q), .roi_top(roi_top_q),
		.done(done), .lane_number(lane_number), .lane_width(lane_width),
		.lane_type(lane_type)
	);
endmodule
`default_nettype wire

FILE: rtl/lloc_checker.sv
// Port-level checks for the lane locator, bound to the top level.
`default_nettype none
module lloc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic done,
	input wire logic [lloc_pkg::LANE_W-1:0]  lane_number,
	input wire logic [lloc_pkg::LTYPE_W-1:0] lane_type
);
	// a query needs many cycles, so results never come close together
	a_done_gap1: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobes in adjacent cycles");
	a_done_gap2: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$past(done, 2))
		else $error("result strobes two cycles apart");
	// no lane and no type go together
	a_lane_type: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((lane_number == '1) == (lane_type == '1)))
		else $error("lane number and lane type disagree on a missing lane");
endmodule

bind lane_locator_unit lloc_checker u_lloc_checker (
	.clk(clk), .arst_n(arst_n), .done(done),
	.lane_number(lane_number), .lane_type(lane_type)
);
`default_nettype wire

FILE: tb/sv/lane_locator_check.sv
// Checker for the lane locator: mirrors the line table, predicts query results and compares.
`timescale 1ns / 1ps
module lane_locator_check #(
	parameter int MAX_LINES = 8,
	parameter int COORD_BITS = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic busy,
	input  wire logic kind,
	input  wire logic [lloc_pkg::IDX_W-1:0]  line_index,
	input  wire logic [COORD_BITS-1:0]       top_x,
	input  wire logic [COORD_BITS-1:0]       top_y,
	input  wire logic [COORD_BITS-1:0]       bottom_x,
	input  wire logic [COORD_BITS-1:0]       bottom_y,
	input  wire logic [lloc_pkg::TYPE_W-1:0] line_type,
	input  wire logic [COORD_BITS-1:0]       point_x,
	input  wire logic [COORD_BITS-1:0]       point_y,
	input  wire logic                        cfg_we,
	input  wire logic [lloc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lloc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                        done,
	input  wire logic [lloc_pkg::LANE_W-1:0]  lane_number,
	input  wire logic [lloc_pkg::WIDTH_W-1:0] lane_width,
	input  wire logic [lloc_pkg::LTYPE_W-1:0] lane_type,
	output int                               errors,
	output int                               pending
);
	import lloc_pkg::*;

	typedef struct packed {
		logic [LANE_W-1:0]  num;
		logic [WIDTH_W-1:0] width;
		logic [LTYPE_W-1:0] ltype;
	} lane_answer_t;

	longint            tbl_tx[MAX_LINES], tbl_ty[MAX_LINES];
	longint            tbl_bx[MAX_LINES], tbl_by[MAX_LINES];
	logic [TYPE_W-1:0] tbl_type[MAX_LINES];
	logic [LC_W-1:0]   lines_in_use;
	logic [ROI_W-1:0]  left_off, top_off;
	lane_answer_t      answers[$];

	// Q.8 x of the line through (ax,ay),(cx,cy) at row y; SV division truncates toward zero.
	function automatic longint q8_line_x(longint ax, longint ay, longint cx, longint cy,
			longint y);
		longint dx, dy;
		dx = cx - ax;
		dy = cy - ay;
		if (dx == 0) dx = 1;
		if (dy == 0) dy = 1;
		return ax * 256 + ((dx * 256) / dy) * (y - ay) + 128;
	endfunction

	function automatic lane_answer_t locate_point(longint px, longint py);
		lane_answer_t a;
		int n, m, lane;
		bit found;
		longint x, prev, gap, w;
		n = lines_in_use;
		if (n < 2) n = 2;
		if (n > MAX_LINES) n = MAX_LINES;
		m = n - 1;
		lane = -1;
		found = 0;
		x = 0;
		prev = -256;
		for (int i = 0; i <= m; i++) begin
			x = q8_line_x(tbl_tx[i], tbl_ty[i], tbl_bx[i], tbl_by[i], py);
			if (x / 256 >= px) begin
				lane = i - 1;
				found = 1;
				break;
			end
			prev = x;
		end
		// left of all lines: compare line 0 with line 1 taken from its bottom end
		if (lane == -1 && found)
			prev = q8_line_x(tbl_bx[1], tbl_by[1], tbl_tx[1], tbl_ty[1], py);
		else if (lane == -1)
			prev = q8_line_x(tbl_tx[m-1], tbl_ty[m-1], tbl_bx[m-1], tbl_by[m-1], py);
		gap = x - prev;
		if (gap < 0) gap = -gap;
		w = (gap == 0) ? 1 : (gap + 128) / 256;
		if (w > 65535) w = 65535;
		a.num = LANE_W'(lane);
		a.width = WIDTH_W'(w);
		a.ltype = (lane >= 0 && lane < m) ? {1'b0, tbl_type[lane]} : '1;
		return a;
	endfunction

	task automatic report(string what);
		$display("%0t: lane result mismatch: %s", $time, what);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		lane_answer_t exp_a;
		if (!arst_n) begin
			lines_in_use <= LINE_COUNT_RST;
			left_off <= '0;
			top_off <= '0;
			answers.delete();
			pending = 0;
		end else begin
			if (done) begin
				if (answers.size() == 0) begin
					report("result with no query waiting");
				end else begin
					exp_a = answers.pop_front();
					if (lane_number !== exp_a.num)
						report($sformatf("lane_number %0h, want %0h", lane_number, exp_a.num));
					if (lane_width !== exp_a.width)
						report($sformatf("lane_width %0d, want %0d", lane_width, exp_a.width));
					if (lane_type !== exp_a.ltype)
						report($sformatf("lane_type %0h, want %0h", lane_type, exp_a.ltype));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
				CFG_LINE_COUNT: lines_in_use <= cfg_data[LC_W-1:0];
				CFG_ROI_LEFT: left_off <= cfg_data[ROI_W-1:0];
				CFG_ROI_TOP: top_off <= cfg_data[ROI_W-1:0];
				default: ;
				endcase
			end
			if (start && !busy) begin
				if (kind == KIND_LOAD) begin
					if (line_index < MAX_LINES) begin
						tbl_tx[line_index] = top_x;
						tbl_ty[line_index] = top_y;
						tbl_bx[line_index] = bottom_x;
						tbl_by[line_index] = bottom_y;
						tbl_type[line_index] = line_type;
					end
				end else begin
					answers.push_back(locate_point(longint'(point_x) + left_off,
						longint'(point_y) + top_off));
				end
			end
			pending = answers.size();
		end
	end
endmodule

FILE: tb/sv/lane_locator_unit_test.sv
// Top of the lane locator testbench: reset, stimulus phases and verdict.
`timescale 1ns / 1ps
module lane_locator_unit_test;
	import lloc_pkg::*;

	localparam int MAX_LINES = 8;
	localparam int COORD_BITS = 12;
	localparam int CYCLE_LIMIT = 3000000;
	// a query walks up to eight lines; settle well past the longest query
	localparam int SETTLE_CYCLES = 300;

	logic clk, arst_n, start, kind, cfg_we;
	logic busy, done;
	logic [IDX_W-1:0]      line_index;
	logic [COORD_BITS-1:0] top_x, top_y, bottom_x, bottom_y, point_x, point_y;
	logic [TYPE_W-1:0]     line_type;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic [LANE_W-1:0]     lane_number;
	logic [WIDTH_W-1:0]    lane_width;
	logic [LTYPE_W-1:0]    lane_type;
	int errors, pending, cycles, idle_pct, sent;

	lane_locator_unit #(.MAX_LINES(MAX_LINES), .COORD_BITS(COORD_BITS)) dut (.*);
	lane_locator_check #(.MAX_LINES(MAX_LINES), .COORD_BITS(COORD_BITS)) checker_i (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// watchdog: a hung block ends the run here
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Present one request and hold it until the block takes it (start high, busy low).
	task automatic issue(logic k, int idx, int tx, int ty, int bx, int by,
			int ty8, int px, int py);
		start <= 1'b1;
		kind <= k;
		line_index <= IDX_W'(idx);
		top_x <= COORD_BITS'(tx);
		top_y <= COORD_BITS'(ty);
		bottom_x <= COORD_BITS'(bx);
		bottom_y <= COORD_BITS'(by);
		line_type <= TYPE_W'(ty8);
		point_x <= COORD_BITS'(px);
		point_y <= COORD_BITS'(py);
		do @(posedge clk); while (busy);
		sent++;
		// drop start for a random gap at the current idle rate
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic load_line(int idx, int tx, int ty, int bx, int by, int lt);
		issue(KIND_LOAD, idx, tx, ty, bx, by, lt, $urandom, $urandom);
	endtask

	task automatic query(int px, int py);
		issue(KIND_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, px, py);
	endtask

	// Load line idx as a plausible left-to-right boundary, now and then degenerate.
	task automatic load_ordered(int idx);
		int tx, bx, ty, by;
		tx = idx * 480 + $urandom_range(0, 400);
		bx = tx + $urandom_range(0, 600) - 300;
		if (bx < 0) bx = 0;
		if (bx > 4095) bx = 4095;
		ty = $urandom_range(0, 1200);
		by = $urandom_range(1200, 4095);
		case ($urandom_range(9))
		0: bx = tx;
		1: by = ty;
		default: ;
		endcase
		load_line(idx, tx, ty, bx, by, $urandom);
	endtask

	// Hold intake until every result is back and the walker has drained.
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Hold the write enable high; the caller drops it after the last write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
	endtask

	task automatic setup(int count, int left, int top);
		wait_idle();
		write_reg(CFG_LINE_COUNT, count);
		write_reg(CFG_ROI_LEFT, left);
		write_reg(CFG_ROI_TOP, top);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int counts[6] = '{8, 2, 0, 15, 5, 1};
		int lefts[6]  = '{0, 4095, 100, 0, 777, 2000};
		int tops[6]   = '{0, 4095, 50, 4095, 333, 0};
		int n;
		arst_n = 0;
		start = 0;
		kind = KIND_LOAD;
		line_index = '0;
		{top_x, top_y, bottom_x, bottom_y, point_x, point_y} = '0;
		line_type = '0;
		cfg_we = 0;
		cfg_index = CFG_LINE_COUNT;
		cfg_data = '0;
		cycles = 0;
		sent = 0;
		idle_pct = 16;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: fill the whole table so no query ever reads an unwritten entry.
		for (int i = 0; i < MAX_LINES; i++) load_ordered(i);
		// reset setting (two lines): left of all, right of all, inside
		query(0, 0);
		query(4095, 4095);
		query(500, 2000);
		// identical lines give a zero gap; so do near-identical ones, as the slope truncates to zero
		load_line(0, 1000, 0, 1000, 4095, 8'h00);
		load_line(1, 1000, 0, 1000, 4095, 8'hff);
		query(1000, 100);
		query(0, 100);
		load_line(1, 1000, 0, 1001, 4095, 8'h5a);
		query(1001, 4095);
		// horizontal line with full dx: steep Q.8 values saturate the width
		load_line(0, 0, 0, 4095, 0, 8'h11);
		load_line(1, 4095, 4095, 0, 4095, 8'h22);
		query(4095, 4095);
		query(0, 4095);
		query(4095, 0);
		// dx and dy both zero
		load_line(0, 4095, 4095, 4095, 4095, 8'h80);
		query(2048, 0);
		load_line(0, 0, 0, 0, 0, 8'h01);
		load_line(1, 2000, 0, 2000, 4095, 8'hfe);
		query(0, 0);
		query(4095, 4095);

		// Random phases, each under a new register setting; extremes included.
		for (int ph = 0; ph < 6; ph++) begin
			setup(counts[ph], lefts[ph], tops[ph]);
			for (int i = 0; i < MAX_LINES; i++) load_ordered(i);
			for (int k = 0; k < 80; k++) begin
				n = $urandom_range(99);
				if (n < 15) begin
					load_ordered($urandom_range(MAX_LINES - 1));
				end else if (n < 22) begin
					load_line($urandom_range(MAX_LINES - 1), $urandom, $urandom,
						$urandom, $urandom, $urandom);
				end else if (n < 60) begin
					query($urandom_range(0, 4095), $urandom_range(0, 4095));
				end else begin
					// keep x, before the roi_left offset, in the span the lines cover
					query($urandom_range(0, 3800), $urandom_range(0, 4095));
				end
				if (ph == 3 && k == 40) wait_idle();
			end
			// sender idle rate: light, then heavy, then none
			if (ph == 1) idle_pct = 79;
			if (ph == 3) idle_pct = 0;
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
